// ----- design/link_error_counters_fault_log_defines.svh -----
// Assertion macros for the link error counter and fault log block.
// Used by the port checker; no other dependencies.
`ifndef LINK_ERROR_COUNTERS_FAULT_LOG_DEFINES_SVH
`define LINK_ERROR_COUNTERS_FAULT_LOG_DEFINES_SVH

// check a property outside reset
`define LEC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lec check failed");

// check a property at every edge, reset included
`define LEC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lec check failed during reset");

`endif

// ----- design/lec_pkg.sv -----
// Shared types and constants for the link error counter and fault log block.
// No dependencies.
`default_nettype none

package lec_pkg;

  localparam int NUM_COUNTERS = 13;
  localparam int PAGE_LIMIT = 64;
  localparam int LINK_COUNT_DEFAULT = 4;
  localparam int LOG_DEPTH_DEFAULT = 64;
  localparam int COUNTER_WIDTH_DEFAULT = 32;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [3:0] SEL_LAST_ERROR = 4'd13;

  typedef enum logic [2:0] {
    OP_INC        = 3'd0,
    OP_SET_ERROR  = 3'd1,
    OP_PUSH_FAULT = 3'd2,
    OP_READ       = 3'd3,
    OP_CLEAR_LINK = 3'd4,
    OP_READ_PAGE  = 3'd5,
    OP_CLEAR_LOG  = 3'd6,
    OP_DROPPED    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_READ,
    ST_SETUP,
    ST_PAGE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  link;
    logic        link_ok;
    logic        sel_cnt;
    logic        sel_err;
    logic [3:0]  sel;
    logic [15:0] error_code;
    logic [7:0]  severity;
    logic [7:0]  sequence_req;
    logic [7:0]  message_type;
    logic [15:0] extra_a;
    logic [15:0] extra_b;
    logic [31:0] timestamp_ms;
    logic [7:0]  cursor;
    logic [7:0]  record_limit;
  } cmd_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [3:0]  link;
    logic [7:0]  severity;
    logic [15:0] error_code;
    logic [7:0]  sequence_num;
    logic [7:0]  message_type;
    logic [15:0] extra_a;
    logic [15:0] extra_b;
  } log_rec_t;

endpackage

`default_nettype wire

// ----- design/lec_front.sv -----
// Front end: accepts and classifies commands into a two-entry queue.
// Depends on lec_pkg.
`default_nettype none

module lec_front #(
  parameter int LINK_COUNT = lec_pkg::LINK_COUNT_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [2:0]   op,
  input  wire logic [3:0]   link,
  input  wire logic [3:0]   counter_select,
  input  wire logic [15:0]  error_code,
  input  wire logic [7:0]   severity,
  input  wire logic [7:0]   sequence_req,
  input  wire logic [7:0]   message_type,
  input  wire logic [15:0]  extra_a,
  input  wire logic [15:0]  extra_b,
  input  wire logic [31:0]  timestamp_ms,
  input  wire logic [7:0]   cursor,
  input  wire logic [7:0]   record_limit,
  output logic              cmd_valid,
  output lec_pkg::cmd_t     cmd,
  input  wire logic         cmd_pop
);

  lec_pkg::cmd_t q [2];
  lec_pkg::cmd_t in_cmd;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          push;

  always_comb begin
    in_cmd.op           = lec_pkg::op_t'(op);
    in_cmd.link         = link;
    in_cmd.link_ok      = {1'b0, link} < 5'(LINK_COUNT);
    in_cmd.sel_cnt      = counter_select < 4'(lec_pkg::NUM_COUNTERS);
    in_cmd.sel_err      = counter_select == lec_pkg::SEL_LAST_ERROR;
    in_cmd.sel          = counter_select;
    in_cmd.error_code   = error_code;
    in_cmd.severity     = severity;
    in_cmd.sequence_req = sequence_req;
    in_cmd.message_type = message_type;
    in_cmd.extra_a      = extra_a;
    in_cmd.extra_b      = extra_b;
    in_cmd.timestamp_ms = timestamp_ms;
    in_cmd.cursor       = cursor;
    in_cmd.record_limit = record_limit;
  end

  assign busy      = count == 2'd2;
  assign push      = start && !busy;
  assign cmd_valid = count != 2'd0;
  assign cmd       = q[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !cmd_pop) begin
      count_next = count + 2'd1;
    end else if (!push && cmd_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/lec_back.sv -----
// Back end: executes queued commands on the counter store and the fault log.
// Depends on lec_pkg.
`default_nettype none

module lec_back #(
  parameter int LINK_COUNT    = lec_pkg::LINK_COUNT_DEFAULT,
  parameter int LOG_DEPTH     = lec_pkg::LOG_DEPTH_DEFAULT,
  parameter int COUNTER_WIDTH = lec_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  wire lec_pkg::cmd_t cmd,
  output logic              cmd_pop,
  output logic              strobe,
  output logic [1:0]        result_kind,
  output logic [31:0]       value,
  output logic [3:0]        rec_link,
  output logic [7:0]        rec_severity,
  output logic [15:0]       rec_error_code,
  output logic [7:0]        rec_sequence,
  output logic [7:0]        rec_message_type,
  output logic [15:0]       rec_extra_a,
  output logic [15:0]       rec_extra_b,
  output logic [7:0]        resume_cursor,
  output logic              last
);

  localparam int LW        = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
  localparam int CNT_DEPTH = LINK_COUNT * lec_pkg::NUM_COUNTERS;
  localparam int CAW       = $clog2(CNT_DEPTH);
  localparam int LAW       = $clog2(LOG_DEPTH);
  localparam int FW        = $clog2(LOG_DEPTH + 1);
  localparam int LIM_CAP   = (LOG_DEPTH < lec_pkg::PAGE_LIMIT) ? LOG_DEPTH : lec_pkg::PAGE_LIMIT;

  lec_pkg::state_t state;
  lec_pkg::state_t state_next;

  logic [COUNTER_WIDTH-1:0] cnt_mem [CNT_DEPTH];
  logic [CNT_DEPTH-1:0]     cnt_valid;
  logic [COUNTER_WIDTH-1:0] cnt_rdata;
  logic                     cnt_rvalid;
  logic [COUNTER_WIDTH-1:0] cnt_cur;
  logic [7:0]               addr_full;
  logic [CAW-1:0]           cnt_addr;
  logic [CAW-1:0]           cur_addr;

  logic [15:0]              last_error [LINK_COUNT];
  logic [15:0]              err_rd;
  logic [LW-1:0]            link_idx;

  lec_pkg::log_rec_t        log_mem [LOG_DEPTH];
  lec_pkg::log_rec_t        log_q;
  lec_pkg::log_rec_t        new_rec;
  logic [LAW-1:0]           head;
  logic [FW-1:0]            fill;
  logic [31:0]              dropped;

  logic [7:0]               lim;
  logic [7:0]               fill8;
  logic                     page_empty;
  logic [7:0]               cur0;
  logic [LAW:0]             oldest_sum;
  logic [LAW-1:0]           oldest;
  logic [7:0]               page_cur;
  logic [7:0]               page_lim;
  logic [LAW-1:0]           page_oldest;
  logic [7:0]               avail;
  logic [7:0]               page_n;
  logic [LAW:0]             idx_sum;
  logic [LAW-1:0]           page_idx;
  logic [7:0]               page_left;
  logic [7:0]               page_nxt;
  logic                     rec_pend;
  logic                     rec_last;

  logic                     cnt_rd;
  logic                     cnt_wr;
  logic                     clr_link;
  logic                     err_wr;
  logic [15:0]              err_data;
  logic                     log_wr;
  logic                     log_clr;
  logic                     page_start;
  logic                     page_step;
  logic                     emit;
  logic [1:0]               emit_kind;
  logic [31:0]              emit_value;
  logic [7:0]               emit_ncur;

  logic                     o_strobe;
  logic [1:0]               o_kind;
  logic [31:0]              o_value;
  logic [7:0]               o_ncur;

  assign addr_full = 8'({4'd0, cmd.link} * 8'(lec_pkg::NUM_COUNTERS)) + {4'd0, cmd.sel};
  assign cnt_addr  = addr_full[CAW-1:0];
  assign link_idx  = cmd.link[LW-1:0];
  assign err_rd    = cmd.link_ok ? last_error[link_idx] : 16'd0;
  assign cnt_cur   = cnt_rvalid ? cnt_rdata : '0;

  assign lim        = (cmd.record_limit > 8'(LIM_CAP)) ? 8'(LIM_CAP) : cmd.record_limit;
  assign fill8      = 8'(fill);
  assign page_empty = (lim == 8'd0) || (fill == '0);
  assign cur0       = (cmd.cursor >= fill8) ? 8'd0 : cmd.cursor;
  assign oldest_sum = ({1'b0, head} >= (LAW+1)'(fill)) ? {1'b0, head} - (LAW+1)'(fill)
                    : {1'b0, head} + (LAW+1)'(LOG_DEPTH) - (LAW+1)'(fill);
  assign oldest     = oldest_sum[LAW-1:0];
  assign avail      = fill8 - page_cur;
  assign page_n     = (page_lim < avail) ? page_lim : avail;
  assign idx_sum    = {1'b0, page_oldest} + (LAW+1)'(page_cur);

  always_comb begin
    new_rec.stamp        = cmd.timestamp_ms;
    new_rec.link         = cmd.link;
    new_rec.severity     = cmd.severity;
    new_rec.error_code   = cmd.error_code;
    new_rec.sequence_num = cmd.sequence_req;
    new_rec.message_type = cmd.message_type;
    new_rec.extra_a      = cmd.extra_a;
    new_rec.extra_b      = cmd.extra_b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lec_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            lec_pkg::OP_INC: begin
              if (cmd.link_ok && cmd.sel_cnt) state_next = lec_pkg::ST_INC;
            end
            lec_pkg::OP_READ: begin
              if (cmd.link_ok && cmd.sel_cnt) state_next = lec_pkg::ST_READ;
            end
            lec_pkg::OP_READ_PAGE: begin
              if (!page_empty) state_next = lec_pkg::ST_SETUP;
            end
            default: state_next = lec_pkg::ST_IDLE;
          endcase
        end
      end
      lec_pkg::ST_INC:   state_next = lec_pkg::ST_IDLE;
      lec_pkg::ST_READ:  state_next = lec_pkg::ST_IDLE;
      lec_pkg::ST_SETUP: state_next = lec_pkg::ST_PAGE;
      lec_pkg::ST_PAGE: begin
        if (page_left == 8'd1) state_next = lec_pkg::ST_IDLE;
      end
      default: state_next = lec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    cnt_rd     = 1'b0;
    cnt_wr     = 1'b0;
    clr_link   = 1'b0;
    err_wr     = 1'b0;
    err_data   = cmd.error_code;
    log_wr     = 1'b0;
    log_clr    = 1'b0;
    page_start = 1'b0;
    page_step  = 1'b0;
    emit       = 1'b0;
    emit_kind  = lec_pkg::KIND_ACK;
    emit_value = 32'd0;
    emit_ncur  = 8'd0;
    unique case (state)
      lec_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            lec_pkg::OP_INC: begin
              cnt_rd = cmd.link_ok && cmd.sel_cnt;
              emit   = !(cmd.link_ok && cmd.sel_cnt);
            end
            lec_pkg::OP_SET_ERROR: begin
              err_wr = cmd.link_ok;
              emit   = 1'b1;
            end
            lec_pkg::OP_PUSH_FAULT: begin
              err_wr = cmd.link_ok;
              log_wr = cmd.link_ok;
              emit   = 1'b1;
            end
            lec_pkg::OP_READ: begin
              cnt_rd     = cmd.link_ok && cmd.sel_cnt;
              emit       = !(cmd.link_ok && cmd.sel_cnt);
              emit_kind  = lec_pkg::KIND_VALUE;
              emit_value = cmd.sel_err ? {16'd0, err_rd} : 32'd0;
            end
            lec_pkg::OP_CLEAR_LINK: begin
              clr_link = cmd.link_ok;
              err_wr   = cmd.link_ok;
              err_data = 16'd0;
              emit     = 1'b1;
            end
            lec_pkg::OP_READ_PAGE: begin
              page_start = !page_empty;
              emit       = page_empty;
              emit_kind  = lec_pkg::KIND_EMPTY;
              emit_ncur  = cmd.cursor;
            end
            lec_pkg::OP_CLEAR_LOG: begin
              log_clr = 1'b1;
              emit    = 1'b1;
            end
            lec_pkg::OP_DROPPED: begin
              emit       = 1'b1;
              emit_kind  = lec_pkg::KIND_VALUE;
              emit_value = dropped;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      lec_pkg::ST_INC: begin
        cnt_wr = 1'b1;
        emit   = 1'b1;
      end
      lec_pkg::ST_READ: begin
        emit       = 1'b1;
        emit_kind  = lec_pkg::KIND_VALUE;
        emit_value = 32'(cnt_cur);
      end
      lec_pkg::ST_SETUP: begin
      end
      lec_pkg::ST_PAGE: begin
        page_step = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_rd) begin
      cnt_rdata  <= cnt_mem[cnt_addr];
      cnt_rvalid <= cnt_valid[cnt_addr];
      cur_addr   <= cnt_addr;
    end
    if (cnt_wr) begin
      cnt_mem[cur_addr] <= cnt_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (log_wr) begin
      log_mem[head] <= new_rec;
    end
    if (page_step) begin
      log_q <= log_mem[page_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind  <= emit_kind;
      o_value <= emit_value;
      o_ncur  <= emit_ncur;
    end
    if (page_start) begin
      page_cur    <= cur0;
      page_lim    <= lim;
      page_oldest <= oldest;
    end
    if (state == lec_pkg::ST_SETUP) begin
      page_nxt <= (page_n == avail) ? 8'd0 : page_cur + page_n;
      page_idx <= (idx_sum >= (LAW+1)'(LOG_DEPTH)) ? LAW'(idx_sum - (LAW+1)'(LOG_DEPTH))
                : idx_sum[LAW-1:0];
    end else if (page_step) begin
      page_idx <= (page_idx == LAW'(LOG_DEPTH - 1)) ? '0 : page_idx + 1'b1;
    end
    if (page_step) begin
      rec_last <= page_left == 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lec_pkg::ST_IDLE;
      cnt_valid <= '0;
      head      <= '0;
      fill      <= '0;
      dropped   <= 32'd0;
      o_strobe  <= 1'b0;
      rec_pend  <= 1'b0;
      page_left <= 8'd0;
      for (int i = 0; i < LINK_COUNT; i++) begin
        last_error[i] <= 16'd0;
      end
    end else begin
      state    <= state_next;
      o_strobe <= emit;
      rec_pend <= page_step;
      if (cnt_wr) begin
        cnt_valid[cur_addr] <= 1'b1;
      end
      if (clr_link) begin
        for (int i = 0; i < CNT_DEPTH; i++) begin
          if (4'(i / lec_pkg::NUM_COUNTERS) == cmd.link) cnt_valid[i] <= 1'b0;
        end
      end
      if (err_wr) begin
        last_error[link_idx] <= err_data;
      end
      if (log_wr) begin
        head <= (head == LAW'(LOG_DEPTH - 1)) ? '0 : head + 1'b1;
        if (fill == FW'(LOG_DEPTH)) begin
          dropped <= dropped + 32'd1;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      if (log_clr) begin
        head    <= '0;
        fill    <= '0;
        dropped <= 32'd0;
      end
      if (state == lec_pkg::ST_SETUP) begin
        page_left <= page_n;
      end else if (page_step) begin
        page_left <= page_left - 8'd1;
      end
    end
  end

  assign strobe           = o_strobe || rec_pend;
  assign result_kind      = rec_pend ? lec_pkg::KIND_RECORD : o_kind;
  assign value            = rec_pend ? log_q.stamp : o_value;
  assign rec_link         = rec_pend ? log_q.link : 4'd0;
  assign rec_severity     = rec_pend ? log_q.severity : 8'd0;
  assign rec_error_code   = rec_pend ? log_q.error_code : 16'd0;
  assign rec_sequence     = rec_pend ? log_q.sequence_num : 8'd0;
  assign rec_message_type = rec_pend ? log_q.message_type : 8'd0;
  assign rec_extra_a      = rec_pend ? log_q.extra_a : 16'd0;
  assign rec_extra_b      = rec_pend ? log_q.extra_b : 16'd0;
  assign resume_cursor    = rec_pend ? page_nxt : o_ncur;
  assign last             = rec_pend ? rec_last : 1'b1;

endmodule

`default_nettype wire

// ----- design/link_error_counters_fault_log.sv -----
// Top level of the per-link error counter and fault log block.
// Depends on lec_pkg, lec_front and lec_back.
//
// Commands enter through start/busy into a two-entry queue; busy is high while
// the queue is full. The back end takes one command at a time: an increment or
// read of a valid event counter reads the counter memory, then writes or
// delivers the value; other single-result commands finish in the idle state;
// a page read passes the idle and setup states, then yields one record per
// cycle, paced by the single read port of the log memory. Each result appears
// on the cycle after the back end produces it, for exactly one cycle with strobe
// high, and cannot be held off; last marks the final result of a command.
// No clearing pass runs after reset.
`default_nettype none

module link_error_counters_fault_log #(
  parameter int LINK_COUNT    = lec_pkg::LINK_COUNT_DEFAULT,
  parameter int LOG_DEPTH     = lec_pkg::LOG_DEPTH_DEFAULT,
  parameter int COUNTER_WIDTH = lec_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [2:0]   op,
  input  wire logic [3:0]   link,
  input  wire logic [3:0]   counter_select,
  input  wire logic [15:0]  error_code,
  input  wire logic [7:0]   severity,
  input  wire logic [7:0]   sequence_req,
  input  wire logic [7:0]   message_type,
  input  wire logic [15:0]  extra_a,
  input  wire logic [15:0]  extra_b,
  input  wire logic [31:0]  timestamp_ms,
  input  wire logic [7:0]   cursor,
  input  wire logic [7:0]   record_limit,
  output logic              strobe,
  output logic [1:0]        result_kind,
  output logic [31:0]       value,
  output logic [3:0]        rec_link,
  output logic [7:0]        rec_severity,
  output logic [15:0]       rec_error_code,
  output logic [7:0]        rec_sequence,
  output logic [7:0]        rec_message_type,
  output logic [15:0]       rec_extra_a,
  output logic [15:0]       rec_extra_b,
  output logic [7:0]        resume_cursor,
  output logic              last
);

  logic          cmd_valid;
  logic          cmd_pop;
  lec_pkg::cmd_t cmd;

  lec_front #(
    .LINK_COUNT(LINK_COUNT)
  ) u_front (
    .clk, .rst, .start, .busy, .op, .link, .counter_select, .error_code,
    .severity, .sequence_req, .message_type, .extra_a, .extra_b,
    .timestamp_ms, .cursor, .record_limit,
    .cmd_valid, .cmd, .cmd_pop
  );

  lec_back #(
    .LINK_COUNT(LINK_COUNT),
    .LOG_DEPTH(LOG_DEPTH),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop,
    .strobe, .result_kind, .value, .rec_link, .rec_severity, .rec_error_code,
    .rec_sequence, .rec_message_type, .rec_extra_a, .rec_extra_b,
    .resume_cursor, .last
  );

endmodule

`default_nettype wire

// ----- design/lec_checker.sv -----
// Port checker for the link error counter and fault log block, with its bind.
// Depends on lec_pkg and link_error_counters_fault_log_defines.svh.
`default_nettype none
`include "link_error_counters_fault_log_defines.svh"

module lec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        strobe,
  input wire logic [1:0]  result_kind,
  input wire logic [31:0] value,
  input wire logic [7:0]  resume_cursor,
  input wire logic        last
);

  logic ack_seen;
  logic empty_seen;
  logic value_seen;
  logic rec_more;

  assign ack_seen   = strobe && result_kind == lec_pkg::KIND_ACK;
  assign empty_seen = strobe && result_kind == lec_pkg::KIND_EMPTY;
  assign value_seen = strobe && result_kind == lec_pkg::KIND_VALUE;
  assign rec_more   = strobe && result_kind == lec_pkg::KIND_RECORD && !last;

  `LEC_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !strobe && !busy)
  `LEC_ASSERT(a_ack_plain, clk, rst, ack_seen |-> value == 32'd0 && last)
  `LEC_ASSERT(a_empty_single, clk, rst, empty_seen |-> value == 32'd0 && last)
  `LEC_ASSERT(a_value_single, clk, rst, value_seen |-> last && resume_cursor == 8'd0)
  `LEC_ASSERT(a_page_burst, clk, rst, rec_more |=> strobe && result_kind == lec_pkg::KIND_RECORD)

endmodule

bind link_error_counters_fault_log lec_checker u_lec_checker (
  .clk(clk), .rst(rst), .busy(busy), .strobe(strobe), .result_kind(result_kind),
  .value(value), .resume_cursor(resume_cursor), .last(last)
);

`default_nettype wire

// ----- tb/lec_checker.sv -----
// Scoreboard for the link error counter and fault log block: predicts results of
// accepted items and compares each strobed result in order. Depends on lec_pkg.
`timescale 1ns / 100ps

module lec_monitor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  op,
  input  wire logic [3:0]  link,
  input  wire logic [3:0]  counter_select,
  input  wire logic [15:0] error_code,
  input  wire logic [7:0]  severity,
  input  wire logic [7:0]  sequence_req,
  input  wire logic [7:0]  message_type,
  input  wire logic [15:0] extra_a,
  input  wire logic [15:0] extra_b,
  input  wire logic [31:0] timestamp_ms,
  input  wire logic [7:0]  cursor,
  input  wire logic [7:0]  record_limit,
  input  wire logic        strobe,
  input  wire logic [1:0]  result_kind,
  input  wire logic [31:0] value,
  input  wire logic [3:0]  rec_link,
  input  wire logic [7:0]  rec_severity,
  input  wire logic [15:0] rec_error_code,
  input  wire logic [7:0]  rec_sequence,
  input  wire logic [7:0]  rec_message_type,
  input  wire logic [15:0] rec_extra_a,
  input  wire logic [15:0] rec_extra_b,
  input  wire logic [7:0]  resume_cursor,
  input  wire logic        last,
  output int               fail_count,
  output int               pending
);

  localparam int LINKS = lec_pkg::LINK_COUNT_DEFAULT;
  localparam int DEPTH = lec_pkg::LOG_DEPTH_DEFAULT;
  localparam int NCNT  = lec_pkg::NUM_COUNTERS;

  typedef struct packed {
    logic [1:0]        kind;
    logic [31:0]       val;
    lec_pkg::log_rec_t rec;
    logic [7:0]        nxt;
    logic              fin;
  } outcome_t;

  logic [31:0]       counters [LINKS*NCNT];
  logic [15:0]       last_code [LINKS];
  lec_pkg::log_rec_t fault_log [DEPTH];
  int unsigned       head, fill;
  logic [31:0]       dropped;
  outcome_t          expected_q [$];

  assign pending = expected_q.size();

  function automatic outcome_t plain(logic [1:0] k, logic [31:0] v);
    outcome_t o;
    o = '0;
    o.kind = k;
    o.val = v;
    o.fin = 1'b1;
    return o;
  endfunction

  task automatic predict_item();
    bit ok;
    int unsigned cur, lim, oldest, n, nxt, i, base;
    lec_pkg::log_rec_t r;
    outcome_t o;
    outcome_t page [$];
    ok = link < LINKS;
    base = link * NCNT;
    case (lec_pkg::op_t'(op))
      lec_pkg::OP_INC: begin
        if (ok && counter_select < NCNT)
          counters[base + counter_select] = counters[base + counter_select] + 32'd1;
        expected_q.push_back(plain(lec_pkg::KIND_ACK, 32'd0));
      end
      lec_pkg::OP_SET_ERROR: begin
        if (ok) last_code[link] = error_code;
        expected_q.push_back(plain(lec_pkg::KIND_ACK, 32'd0));
      end
      lec_pkg::OP_PUSH_FAULT: begin
        if (ok) begin
          r.stamp = timestamp_ms;
          r.link = link;
          r.severity = severity;
          r.error_code = error_code;
          r.sequence_num = sequence_req;
          r.message_type = message_type;
          r.extra_a = extra_a;
          r.extra_b = extra_b;
          if (fill >= DEPTH) dropped = dropped + 32'd1;
          else fill++;
          fault_log[head] = r;
          head = (head + 1) % DEPTH;
          last_code[link] = error_code;
        end
        expected_q.push_back(plain(lec_pkg::KIND_ACK, 32'd0));
      end
      lec_pkg::OP_READ: begin
        o = plain(lec_pkg::KIND_VALUE, 32'd0);
        if (ok) begin
          if (counter_select < NCNT) o.val = counters[base + counter_select];
          else if (counter_select == lec_pkg::SEL_LAST_ERROR) o.val = {16'd0, last_code[link]};
        end
        expected_q.push_back(o);
      end
      lec_pkg::OP_CLEAR_LINK: begin
        if (ok) begin
          for (i = 0; i < NCNT; i++) counters[base + i] = 32'd0;
          last_code[link] = 16'd0;
        end
        expected_q.push_back(plain(lec_pkg::KIND_ACK, 32'd0));
      end
      lec_pkg::OP_READ_PAGE: begin
        cur = cursor;
        lim = record_limit;
        if (lim > DEPTH) lim = DEPTH;
        if (lim > lec_pkg::PAGE_LIMIT) lim = lec_pkg::PAGE_LIMIT;
        if (lim == 0 || fill == 0) begin
          o = plain(lec_pkg::KIND_EMPTY, 32'd0);
          o.nxt = cursor;
          expected_q.push_back(o);
        end else begin
          if (cur >= fill) cur = 0;
          oldest = (head + DEPTH - fill) % DEPTH;
          n = 0;
          for (i = cur; i < fill && n < lim; i++) begin
            o = '0;
            o.kind = lec_pkg::KIND_RECORD;
            o.rec = fault_log[(oldest + i) % DEPTH];
            o.val = o.rec.stamp;
            page.push_back(o);
            n++;
          end
          nxt = cur + n;
          if (nxt >= fill) nxt = 0;
          for (i = 0; i < n; i++) begin
            o = page[i];
            o.nxt = nxt[7:0];
            o.fin = (i == n - 1);
            expected_q.push_back(o);
          end
        end
      end
      lec_pkg::OP_CLEAR_LOG: begin
        head = 0;
        fill = 0;
        dropped = 32'd0;
        expected_q.push_back(plain(lec_pkg::KIND_ACK, 32'd0));
      end
      default: expected_q.push_back(plain(lec_pkg::KIND_VALUE, dropped));
    endcase
  endtask

  task automatic compare_result();
    outcome_t e;
    outcome_t a;
    a.kind = result_kind;
    a.val = value;
    a.rec = '0;
    a.rec.link = rec_link;
    a.rec.severity = rec_severity;
    a.rec.error_code = rec_error_code;
    a.rec.sequence_num = rec_sequence;
    a.rec.message_type = rec_message_type;
    a.rec.extra_a = rec_extra_a;
    a.rec.extra_b = rec_extra_b;
    a.nxt = resume_cursor;
    a.fin = last;
    if (expected_q.size() == 0) begin
      fail_count++;
      $display("%0t unexpected result: expected none, actual %h", $time, a);
    end else begin
      e = expected_q.pop_front();
      e.rec.stamp = '0;
      if (a !== e) begin
        fail_count++;
        $display("%0t mismatch: expected kind %0d value %h link %h sev %h code %h",
                 $time, e.kind, e.val, e.rec.link, e.rec.severity, e.rec.error_code);
        $display("  seq %h type %h a %h b %h next %0d last %b", e.rec.sequence_num,
                 e.rec.message_type, e.rec.extra_a, e.rec.extra_b, e.nxt, e.fin);
        $display("%0t   actual: kind %0d value %h link %h sev %h code %h", $time,
                 a.kind, a.val, a.rec.link, a.rec.severity, a.rec.error_code);
        $display("  seq %h type %h a %h b %h next %0d last %b", a.rec.sequence_num,
                 a.rec.message_type, a.rec.extra_a, a.rec.extra_b, a.nxt, a.fin);
      end
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINKS*NCNT; i++) counters[i] = 32'd0;
      for (int i = 0; i < LINKS; i++) last_code[i] = 16'd0;
      head = 0;
      fill = 0;
      dropped = 32'd0;
      expected_q.delete();
    end else begin
      if (strobe) compare_result();
      if (start && !busy) predict_item();
    end
  end
endmodule

// ----- tb/tb.sv -----
// Testbench top for link_error_counters_fault_log: drives directed and random
// items and reports the verdict. Depends on lec_pkg and lec_monitor.
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] op = '0;
  logic [3:0] link = '0, counter_select = '0;
  logic [15:0] error_code = '0, extra_a = '0, extra_b = '0;
  logic [7:0] severity = '0, sequence_req = '0, message_type = '0;
  logic [7:0] cursor = '0, record_limit = '0;
  logic [31:0] timestamp_ms = '0;
  wire busy, strobe, last;
  wire [1:0] result_kind;
  wire [31:0] value;
  wire [3:0] rec_link;
  wire [7:0] rec_severity, rec_sequence, rec_message_type, resume_cursor;
  wire [15:0] rec_error_code, rec_extra_a, rec_extra_b;
  int fail_count, pending;
  int idle_pct;

  always #10 clk = ~clk;

  link_error_counters_fault_log dut (.*);
  lec_monitor chk (.*);

  task automatic send_item(lec_pkg::op_t o, logic [3:0] l, logic [3:0] s, logic [7:0] c,
                           logic [7:0] m, bit rand_payload);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    op <= o;
    link <= l;
    counter_select <= s;
    cursor <= c;
    record_limit <= m;
    if (rand_payload) begin
      error_code <= 16'($urandom);
      severity <= 8'($urandom);
      sequence_req <= 8'($urandom);
      message_type <= 8'($urandom);
      extra_a <= 16'($urandom);
      extra_b <= 16'($urandom);
      timestamp_ms <= $urandom;
    end
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [3:0] l;
    logic [3:0] s;
    logic [7:0] c;
    logic [7:0] m;
    r = $urandom_range(99);
    l = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    s = 4'($urandom_range(15));
    c = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(70));
    m = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(8));
    if (r < 25) send_item(lec_pkg::OP_PUSH_FAULT, l, s, c, m, 1'b1);
    else if (r < 40) send_item(lec_pkg::OP_INC, l, s, c, m, 1'b1);
    else if (r < 55) send_item(lec_pkg::OP_READ, l, s, c, m, 1'b1);
    else if (r < 62) send_item(lec_pkg::OP_SET_ERROR, l, s, c, m, 1'b1);
    else if (r < 66) send_item(lec_pkg::OP_CLEAR_LINK, l, s, c, m, 1'b1);
    else if (r < 84) send_item(lec_pkg::OP_READ_PAGE, l, s, c, m, 1'b1);
    else if (r < 86) send_item(lec_pkg::OP_CLEAR_LOG, l, s, c, m, 1'b1);
    else send_item(lec_pkg::OP_DROPPED, l, s, c, m, 1'b1);
  endtask

  initial begin
    idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed part
    send_item(lec_pkg::OP_READ_PAGE, 4'd0, 4'd0, 8'd5, 8'd4, 1'b0);
    send_item(lec_pkg::OP_INC, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_INC, 4'd3, 4'd12, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_INC, 4'd2, 4'd13, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_INC, 4'd15, 4'd0, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_READ, 4'd3, 4'd12, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_READ, 4'd0, 4'd15, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_READ, 4'd4, 4'd0, 8'd0, 8'd0, 1'b0);
    error_code <= 16'hffff;
    send_item(lec_pkg::OP_SET_ERROR, 4'd1, 4'd0, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_READ, 4'd1, 4'd13, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_SET_ERROR, 4'd9, 4'd0, 8'd0, 8'd0, 1'b0);
    for (int i = 0; i < 3; i++)
      send_item(lec_pkg::OP_PUSH_FAULT, 4'(i), 4'd0, 8'd0, 8'd0, 1'b1);
    send_item(lec_pkg::OP_PUSH_FAULT, 4'd15, 4'd0, 8'd0, 8'd0, 1'b1);
    send_item(lec_pkg::OP_READ_PAGE, 4'd0, 4'd0, 8'd255, 8'd255, 1'b0);
    send_item(lec_pkg::OP_READ_PAGE, 4'd0, 4'd0, 8'd1, 8'd1, 1'b0);
    send_item(lec_pkg::OP_READ_PAGE, 4'd0, 4'd0, 8'd2, 8'd0, 1'b0);
    send_item(lec_pkg::OP_CLEAR_LINK, 4'd3, 4'd0, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_CLEAR_LINK, 4'd12, 4'd0, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_READ, 4'd3, 4'd12, 8'd0, 8'd0, 1'b0);
    for (int i = 0; i < 66; i++)
      send_item(lec_pkg::OP_PUSH_FAULT, 4'(i % 4), 4'd0, 8'd0, 8'd0, 1'b1);
    send_item(lec_pkg::OP_DROPPED, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_READ_PAGE, 4'd0, 4'd0, 8'd60, 8'd200, 1'b0);
    send_item(lec_pkg::OP_CLEAR_LOG, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0);
    send_item(lec_pkg::OP_DROPPED, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0);
    // random part in three idling phases
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 34 : (p == 1) ? 52 : 0;
      for (int i = 0; i < 70; i++) begin
        random_item();
        if (i == 35) begin
          start <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
